### rtl/cigar_stream_checker_defines.svh
// Assertion macros used by the checker file csc_checker.sv.
`ifndef CIGAR_STREAM_CHECKER_DEFINES_SVH
`define CIGAR_STREAM_CHECKER_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled while rst is high.
`define CSC_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cigar_stream_checker: assertion failed");

// Next-cycle implication, sampled on clk, disabled while rst is high.
`define CSC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cigar_stream_checker: assertion failed");

`endif

### rtl/csc_pkg.sv
package csc_pkg;

  localparam int COUNT_BITS   = 16;
  localparam int OUT_CNT_BITS = 16;
  localparam int OP_BITS      = 4;
  localparam int LEN_BITS     = 28;
  localparam int SUM_BITS     = 32;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  typedef logic [COUNT_BITS-1:0]   cnt_t;
  typedef logic [OUT_CNT_BITS-1:0] out_cnt_t;
  typedef logic [OP_BITS-1:0]      op_bits_t;
  typedef logic [LEN_BITS-1:0]     len_t;
  typedef logic [SUM_BITS-1:0]     sum_t;

  typedef enum logic [OP_BITS-1:0] {
    OP_M  = 4'd0,
    OP_I  = 4'd1,
    OP_D  = 4'd2,
    OP_N  = 4'd3,
    OP_S  = 4'd4,
    OP_H  = 4'd5,
    OP_P  = 4'd6,
    OP_EQ = 4'd7,
    OP_X  = 4'd8
  } op_t;

  // Element position within the CIGAR: first, second, or anything later.
  typedef logic [1:0] pos_t;
  localparam pos_t POS_FIRST  = 2'd0;
  localparam pos_t POS_SECOND = 2'd1;
  localparam pos_t POS_LATER  = 2'd2;

  // One classified element as it travels from the front end to the back end.
  typedef struct packed {
    len_t len;
    logic last;
    logic is_zero;
    logic is_real;
    logic is_clip;
    logic is_s;
    logic is_h;
    logic is_p;
    logic is_i;
    logic is_d;
    logic adds_ref;
    logic adds_padded;
    logic adds_read;
  } entry_t;

  function automatic cnt_t sat_cnt(input cnt_t a, input cnt_t b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
  endfunction

  function automatic sum_t sat_sum(input sum_t a, input len_t b);
    logic [SUM_BITS:0] s;
    s = {1'b0, a} + (SUM_BITS + 1)'(b);
    return s[SUM_BITS] ? '1 : s[SUM_BITS-1:0];
  endfunction

endpackage

### rtl/csc_elem_if.sv
interface csc_elem_if;
  import csc_pkg::*;

  logic     valid;
  logic     ready;
  op_bits_t element_op;
  len_t     element_len;
  logic     is_last;

  modport source (output valid, output element_op, output element_len, output is_last,
                  input ready);
  modport sink (input valid, input element_op, input element_len, input is_last,
                output ready);
endinterface

### rtl/csc_res_if.sv
interface csc_res_if;
  import csc_pkg::*;

  logic     valid;
  logic     ready;
  sum_t     ref_length;
  sum_t     padded_ref_length;
  sum_t     read_length;
  logic     left_clipped;
  logic     right_clipped;
  out_cnt_t zero_len_errors;
  out_cnt_t hard_clip_errors;
  out_cnt_t soft_clip_errors;
  out_cnt_t indel_repeat_errors;
  logic     pad_at_end_error;
  out_cnt_t pad_place_errors;
  logic     no_real_op;

  modport source (output valid, output ref_length, output padded_ref_length,
                  output read_length, output left_clipped, output right_clipped,
                  output zero_len_errors, output hard_clip_errors, output soft_clip_errors,
                  output indel_repeat_errors, output pad_at_end_error,
                  output pad_place_errors, output no_real_op, input ready);
  modport sink (input valid, input ref_length, input padded_ref_length,
                input read_length, input left_clipped, input right_clipped,
                input zero_len_errors, input hard_clip_errors, input soft_clip_errors,
                input indel_repeat_errors, input pad_at_end_error,
                input pad_place_errors, input no_real_op, output ready);
endinterface

### rtl/csc_front.sv
module csc_front (
  csc_elem_if.sink         elem,
  input  logic             full,
  output logic             push,
  output csc_pkg::entry_t  entry
);
  import csc_pkg::*;

  op_t op;

  assign op         = op_t'(elem.element_op);
  assign elem.ready = !full;
  assign push       = elem.valid && !full;

  always_comb begin
    entry             = '0;
    entry.len         = elem.element_len;
    entry.last        = elem.is_last;
    entry.is_zero     = (elem.element_len == '0);
    entry.is_real     = (op == OP_M) || (op == OP_I) || (op == OP_D) || (op == OP_N) ||
                        (op == OP_EQ) || (op == OP_X);
    entry.is_s        = (op == OP_S);
    entry.is_h        = (op == OP_H);
    entry.is_p        = (op == OP_P);
    entry.is_i        = (op == OP_I);
    entry.is_d        = (op == OP_D);
    entry.is_clip     = entry.is_s || entry.is_h;
    entry.adds_ref    = entry.is_real && !entry.is_i;
    entry.adds_padded = entry.adds_ref || entry.is_p;
    entry.adds_read   = (op == OP_M) || (op == OP_I) || (op == OP_S) || (op == OP_EQ) ||
                        (op == OP_X);
  end
endmodule

### rtl/csc_queue.sv
module csc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  csc_pkg::entry_t  wr_entry,
  output logic             full,
  input  logic             pop,
  output logic             rd_valid,
  output csc_pkg::entry_t  rd_entry
);
  import csc_pkg::*;

  entry_t                 slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr;
  logic [QPTR_BITS-1:0]   rd_ptr;
  logic [QCNT_BITS-1:0]   count;
  logic                   do_push;
  logic                   do_pop;

  assign full     = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_entry = slots[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && rd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end
endmodule

### rtl/csc_back.sv
module csc_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  csc_pkg::entry_t  q_head,
  output logic             pop,
  csc_res_if.source        res
);
  import csc_pkg::*;

  entry_t e;

  logic held_valid, held_is_s, before_real, first_is_h, first_is_clip;
  logic prev_real, real_seen, pad_end, res_valid;
  pos_t held_pos, elem_pos;
  sum_t ref_sum, padded_sum, read_sum;
  cnt_t ins_run, del_run;
  cnt_t cnt_zero, cnt_hard, cnt_soft, cnt_indel, cnt_pad;

  logic held_valid_next, held_is_s_next, before_real_next, first_is_h_next;
  logic first_is_clip_next, real_seen_next, pad_end_next;
  pos_t held_pos_next, elem_pos_next;
  sum_t ref_sum_next, padded_sum_next, read_sum_next;
  cnt_t ins_run_next, del_run_next;
  cnt_t cnt_zero_next, cnt_hard_next, cnt_soft_next, cnt_indel_next, cnt_pad_next;

  logic at_first, soft_bad, pad_bad, hold_s, hold_p, run_break;
  cnt_t indel_add;

  assign e   = q_head;
  // A non-final element never produces a result, so it need not wait for the output slot.
  assign pop = q_valid && (!e.last || !res_valid || res.ready);

  always_comb begin
    at_first  = (elem_pos == POS_FIRST);
    soft_bad  = held_valid && held_is_s &&
                !((e.last && e.is_h) || (held_pos == POS_SECOND && first_is_h));
    pad_bad   = held_valid && !held_is_s && (!before_real || !e.is_real);
    hold_s    = e.is_s && !at_first && !e.last;
    hold_p    = e.is_p && !at_first && !e.last;
    run_break = e.is_p || (e.is_real && !e.is_i && !e.is_d);
    indel_add = e.is_i ? ins_run : (e.is_d ? del_run : '0);

    ref_sum_next    = e.adds_ref    ? sat_sum(ref_sum, e.len)    : ref_sum;
    padded_sum_next = e.adds_padded ? sat_sum(padded_sum, e.len) : padded_sum;
    read_sum_next   = e.adds_read   ? sat_sum(read_sum, e.len)   : read_sum;

    cnt_zero_next  = sat_cnt(cnt_zero, cnt_t'(e.is_zero));
    cnt_hard_next  = sat_cnt(cnt_hard, cnt_t'(e.is_h && !at_first && !e.last));
    cnt_soft_next  = sat_cnt(cnt_soft, cnt_t'(soft_bad));
    cnt_pad_next   = sat_cnt(cnt_pad, cnt_t'(pad_bad));
    cnt_indel_next = sat_cnt(cnt_indel, indel_add);

    ins_run_next = run_break ? '0 : (e.is_i ? sat_cnt(ins_run, cnt_t'(1'b1)) : ins_run);
    del_run_next = run_break ? '0 : (e.is_d ? sat_cnt(del_run, cnt_t'(1'b1)) : del_run);

    held_valid_next  = hold_s || hold_p;
    held_is_s_next   = hold_s ? 1'b1 : (hold_p ? 1'b0 : held_is_s);
    held_pos_next    = (hold_s || hold_p) ? elem_pos : held_pos;
    before_real_next = hold_p ? prev_real : before_real;

    first_is_h_next    = at_first ? e.is_h : first_is_h;
    first_is_clip_next = at_first ? e.is_clip : first_is_clip;
    real_seen_next     = real_seen || e.is_real;
    pad_end_next       = pad_end || (e.is_p && !at_first && e.last);
    elem_pos_next      = (elem_pos == POS_LATER) ? POS_LATER : elem_pos + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst || (pop && e.last)) begin
      held_valid    <= 1'b0;
      held_is_s     <= 1'b0;
      held_pos      <= POS_FIRST;
      before_real   <= 1'b0;
      first_is_h    <= 1'b0;
      first_is_clip <= 1'b0;
      prev_real     <= 1'b1;
      real_seen     <= 1'b0;
      pad_end       <= 1'b0;
      elem_pos      <= POS_FIRST;
      ref_sum       <= '0;
      padded_sum    <= '0;
      read_sum      <= '0;
      ins_run       <= '0;
      del_run       <= '0;
      cnt_zero      <= '0;
      cnt_hard      <= '0;
      cnt_soft      <= '0;
      cnt_indel     <= '0;
      cnt_pad       <= '0;
    end else if (pop) begin
      held_valid    <= held_valid_next;
      held_is_s     <= held_is_s_next;
      held_pos      <= held_pos_next;
      before_real   <= before_real_next;
      first_is_h    <= first_is_h_next;
      first_is_clip <= first_is_clip_next;
      prev_real     <= e.is_real;
      real_seen     <= real_seen_next;
      pad_end       <= pad_end_next;
      elem_pos      <= elem_pos_next;
      ref_sum       <= ref_sum_next;
      padded_sum    <= padded_sum_next;
      read_sum      <= read_sum_next;
      ins_run       <= ins_run_next;
      del_run       <= del_run_next;
      cnt_zero      <= cnt_zero_next;
      cnt_hard      <= cnt_hard_next;
      cnt_soft      <= cnt_soft_next;
      cnt_indel     <= cnt_indel_next;
      cnt_pad       <= cnt_pad_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop && e.last) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && e.last) begin
      res.ref_length          <= ref_sum_next;
      res.padded_ref_length   <= padded_sum_next;
      res.read_length         <= read_sum_next;
      res.left_clipped        <= first_is_clip_next;
      res.right_clipped       <= e.is_clip;
      res.zero_len_errors     <= out_cnt_t'(cnt_zero_next);
      res.hard_clip_errors    <= out_cnt_t'(cnt_hard_next);
      res.soft_clip_errors    <= out_cnt_t'(cnt_soft_next);
      res.indel_repeat_errors <= out_cnt_t'(cnt_indel_next);
      res.pad_at_end_error    <= pad_end_next;
      res.pad_place_errors    <= out_cnt_t'(cnt_pad_next);
      res.no_real_op          <= !real_seen_next;
    end
  end

  assign res.valid = res_valid;
endmodule

### rtl/cigar_stream_checker.sv
// A final element is stored in the queue, then registered as the result before it is offered.
// Throughput: one CIGAR element per cycle, sustained, while results are taken.
// A four-entry queue sits between the element decoder and the checking engine,
// so input ready drops only when that queue fills behind a stalled result.
// Reset (rst, synchronous) empties the queue, drops the result valid and clears all sums.
module cigar_stream_checker (
  input  logic       clk,
  input  logic       rst,
  csc_elem_if.sink   elem,
  csc_res_if.source  res
);
  import csc_pkg::*;

  logic   push;
  logic   full;
  logic   pop;
  logic   q_valid;
  entry_t wr_entry;
  entry_t q_head;

  csc_front u_front (
    .elem  (elem),
    .full  (full),
    .push  (push),
    .entry (wr_entry)
  );

  csc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .full     (full),
    .pop      (pop),
    .rd_valid (q_valid),
    .rd_entry (q_head)
  );

  csc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_head  (q_head),
    .pop     (pop),
    .res     (res)
  );
endmodule

### rtl/csc_checker.sv
`include "cigar_stream_checker_defines.svh"

module csc_checker (
  input logic               clk,
  input logic               rst,
  input logic               res_valid,
  input logic               res_ready,
  input csc_pkg::sum_t      ref_length,
  input csc_pkg::sum_t      padded_ref_length,
  input logic               right_clipped,
  input logic               pad_at_end_error,
  input csc_pkg::out_cnt_t  indel_repeat_errors,
  input logic               no_real_op
);
  import csc_pkg::*;

  // A stalled result stays offered and its reference length unchanged.
  `CSC_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(ref_length))

  // The padded length covers everything the reference length does.
  `CSC_ASSERT_NOW(a_padded_ge_ref, res_valid, padded_ref_length >= ref_length)

  // Without any real operator nothing reaches the reference or the indel count.
  `CSC_ASSERT_NOW(a_no_real_empty, res_valid && no_real_op,
                  ref_length == '0 && indel_repeat_errors == '0)

  // A trailing padding element cannot also be a clip.
  `CSC_ASSERT_NOW(a_pad_end_not_clip, res_valid && pad_at_end_error, !right_clipped)

  // Nothing is offered in the first cycle after reset.
  `CSC_ASSERT_NOW(a_quiet_after_reset, $past(rst), !res_valid)
endmodule

bind cigar_stream_checker csc_checker u_csc_checker (
  .clk                 (clk),
  .rst                 (rst),
  .res_valid           (res.valid),
  .res_ready           (res.ready),
  .ref_length          (res.ref_length),
  .padded_ref_length   (res.padded_ref_length),
  .right_clipped       (res.right_clipped),
  .pad_at_end_error    (res.pad_at_end_error),
  .indel_repeat_errors (res.indel_repeat_errors),
  .no_real_op          (res.no_real_op)
);

### tb/cigar_stream_checker_test.sv
`timescale 1ns / 1ps

module cigar_stream_checker_test;
  import csc_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_ITEMS  = 1200;
  localparam int INDEL_RUN     = 400;
  localparam int CLIP_TRIPLES  = 100;
  localparam len_t LEN_MAX     = '1;

  // Codes outside the SAM operator set; the block must treat them as inert.
  localparam op_bits_t OP_UNKNOWN_LO = 4'd9;
  localparam op_bits_t OP_UNKNOWN_HI = 4'd15;

  typedef struct packed {
    sum_t     ref_length;
    sum_t     padded_ref_length;
    sum_t     read_length;
    logic     left_clipped;
    logic     right_clipped;
    out_cnt_t zero_len_errors;
    out_cnt_t hard_clip_errors;
    out_cnt_t soft_clip_errors;
    out_cnt_t indel_repeat_errors;
    logic     pad_at_end_error;
    out_cnt_t pad_place_errors;
    logic     no_real_op;
  } cigar_summary_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  csc_elem_if elem_ch ();
  csc_res_if  res_ch ();

  cigar_stream_checker u_top (
    .clk  (clk),
    .rst  (rst),
    .elem (elem_ch),
    .res  (res_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Running state of the CIGAR being summed.
  logic     parked_valid;
  op_bits_t parked_op;
  pos_t     parked_pos;
  op_bits_t op_before_parked;
  op_bits_t lead_op;
  op_bits_t last_op;
  pos_t     next_pos;
  sum_t     ref_total;
  sum_t     padded_total;
  sum_t     read_total;
  cnt_t     ins_streak;
  cnt_t     del_streak;
  cnt_t     zero_errs;
  cnt_t     hard_errs;
  cnt_t     soft_errs;
  cnt_t     indel_errs;
  cnt_t     pad_errs;
  logic     saw_real;
  logic     pad_last;

  cigar_summary_t expected_summaries[$];
  op_bits_t       cigar_ops[$];
  len_t           cigar_lens[$];

  int          mismatches = 0;
  int unsigned ready_hold = 0;
  bit          idle_on = 1'b1;
  int          cycle_count = 0;

  function automatic logic is_real_op(input op_bits_t op);
    return op <= OP_N || op == OP_EQ || op == OP_X;
  endfunction

  function automatic logic is_clip_op(input op_bits_t op);
    return op == OP_S || op == OP_H;
  endfunction

  function automatic cnt_t count_up(input cnt_t c, input longint unsigned add);
    longint unsigned total;
    longint unsigned ceiling;
    ceiling = (64'd1 << COUNT_BITS) - 1;
    total = longint'(c) + add;
    return (total > ceiling) ? cnt_t'(ceiling) : cnt_t'(total);
  endfunction

  function automatic sum_t grow_sum(input sum_t a, input len_t b);
    longint unsigned total;
    total = longint'(a) + longint'(b);
    return (total > 64'hFFFF_FFFF) ? '1 : sum_t'(total);
  endfunction

  task automatic clear_cigar_state();
    parked_valid = 1'b0;
    parked_op = OP_M;
    parked_pos = POS_FIRST;
    op_before_parked = OP_M;
    lead_op = OP_M;
    last_op = OP_M;
    next_pos = POS_FIRST;
    ref_total = '0;
    padded_total = '0;
    read_total = '0;
    ins_streak = '0;
    del_streak = '0;
    zero_errs = '0;
    hard_errs = '0;
    soft_errs = '0;
    indel_errs = '0;
    pad_errs = '0;
    saw_real = 1'b0;
    pad_last = 1'b0;
  endtask

  // Advances the running state by one accepted element and queues the
  // summary when the element closes the CIGAR.
  task automatic apply_element(input op_bits_t op, input len_t len, input logic last);
    pos_t           pos;
    logic           clip_ok;
    cigar_summary_t s;
    pos = next_pos;
    if (len == 0) zero_errs = count_up(zero_errs, 1);
    if (is_real_op(op) && op != OP_I) ref_total = grow_sum(ref_total, len);
    if ((is_real_op(op) && op != OP_I) || op == OP_P) padded_total = grow_sum(padded_total, len);
    if (op == OP_M || op == OP_I || op == OP_S || op == OP_EQ || op == OP_X) begin
      read_total = grow_sum(read_total, len);
    end

    // A parked element is judged now that its successor is known.
    if (parked_valid) begin
      if (parked_op == OP_S) begin
        clip_ok = (last && op == OP_H) || (parked_pos == POS_SECOND && lead_op == OP_H);
        if (!clip_ok) soft_errs = count_up(soft_errs, 1);
      end else if (!is_real_op(op_before_parked) || !is_real_op(op)) begin
        pad_errs = count_up(pad_errs, 1);
      end
      parked_valid = 1'b0;
    end

    if (pos == POS_FIRST) lead_op = op;

    if (op == OP_H) begin
      if (pos != POS_FIRST && !last) hard_errs = count_up(hard_errs, 1);
    end else if (op == OP_S) begin
      if (pos != POS_FIRST && !last) begin
        parked_valid = 1'b1;
        parked_op = OP_S;
        parked_pos = pos;
      end
    end else if (op == OP_P) begin
      ins_streak = '0;
      del_streak = '0;
      if (pos != POS_FIRST) begin
        if (last) begin
          pad_last = 1'b1;
        end else begin
          parked_valid = 1'b1;
          parked_op = OP_P;
          parked_pos = pos;
          op_before_parked = last_op;
        end
      end
    end else if (op == OP_I) begin
      saw_real = 1'b1;
      indel_errs = count_up(indel_errs, ins_streak);
      ins_streak = count_up(ins_streak, 1);
    end else if (op == OP_D) begin
      saw_real = 1'b1;
      indel_errs = count_up(indel_errs, del_streak);
      del_streak = count_up(del_streak, 1);
    end else if (is_real_op(op)) begin
      saw_real = 1'b1;
      ins_streak = '0;
      del_streak = '0;
    end

    last_op = op;
    next_pos = (pos == POS_LATER) ? POS_LATER : pos_t'(pos + 2'd1);

    if (last) begin
      s.ref_length = ref_total;
      s.padded_ref_length = padded_total;
      s.read_length = read_total;
      s.left_clipped = is_clip_op(lead_op);
      s.right_clipped = is_clip_op(op);
      s.zero_len_errors = out_cnt_t'(zero_errs);
      s.hard_clip_errors = out_cnt_t'(hard_errs);
      s.soft_clip_errors = out_cnt_t'(soft_errs);
      s.indel_repeat_errors = out_cnt_t'(indel_errs);
      s.pad_at_end_error = pad_last;
      s.pad_place_errors = out_cnt_t'(pad_errs);
      s.no_real_op = !saw_real;
      expected_summaries.push_back(s);
      clear_cigar_state();
    end
  endtask

  task automatic report_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
    mismatches++;
    $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
  endtask

  task automatic compare_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) report_mismatch(what, want, got);
  endtask

  task automatic send_element(input op_bits_t op, input len_t len, input logic last);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      elem_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    elem_ch.valid <= 1'b1;
    elem_ch.element_op <= op;
    elem_ch.element_len <= len;
    elem_ch.is_last <= last;
    do @(posedge clk); while (!elem_ch.ready);
    apply_element(op, len, last);
  endtask

  task automatic add_element(input op_bits_t op, input len_t len);
    cigar_ops.push_back(op);
    cigar_lens.push_back(len);
  endtask

  task automatic send_cigar();
    foreach (cigar_ops[i]) begin
      send_element(cigar_ops[i], cigar_lens[i], i == cigar_ops.size() - 1);
    end
    cigar_ops.delete();
    cigar_lens.delete();
  endtask

  function automatic len_t random_len();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return '0;
    if (pick == 1) return LEN_MAX;
    if (pick <= 3) return len_t'($urandom);
    return len_t'($urandom_range(1, 1000));
  endfunction

  function automatic op_bits_t random_body_op();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return OP_M;
    if (pick < 50) return OP_I;
    if (pick < 60) return OP_D;
    if (pick < 65) return OP_N;
    if (pick < 72) return OP_EQ;
    if (pick < 79) return OP_X;
    if (pick < 87) return OP_P;
    if (pick < 91) return OP_S;
    if (pick < 95) return OP_H;
    return op_bits_t'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI));
  endfunction

  // Mostly clip-framed alignments with a random body; one in five is raw noise.
  task automatic queue_random_cigar();
    int body;
    if ($urandom_range(0, 4) == 0) begin
      body = $urandom_range(1, 8);
      repeat (body) add_element(op_bits_t'($urandom_range(0, 15)), random_len());
    end else begin
      if ($urandom_range(0, 2) == 0) add_element(OP_H, random_len());
      if ($urandom_range(0, 2) == 0) add_element(OP_S, random_len());
      body = $urandom_range(1, 10);
      repeat (body) add_element(random_body_op(), random_len());
      if ($urandom_range(0, 2) == 0) add_element(OP_S, random_len());
      if ($urandom_range(0, 2) == 0) add_element(OP_H, random_len());
    end
  endtask

  task automatic test_directed();
    add_element(OP_M, LEN_MAX);
    send_cigar();
    add_element(OP_P, 5);
    send_cigar();
    add_element(OP_S, 0);
    send_cigar();

    // Both clip types framing every real operator, all in allowed places.
    add_element(OP_H, 3);
    add_element(OP_S, 4);
    add_element(OP_M, 10);
    add_element(OP_I, 2);
    add_element(OP_D, 1);
    add_element(OP_N, 7);
    add_element(OP_EQ, 6);
    add_element(OP_X, 5);
    add_element(OP_S, 2);
    add_element(OP_H, 1);
    send_cigar();

    add_element(OP_M, 5);
    add_element(OP_P, 2);
    add_element(OP_M, 3);
    add_element(OP_P, 1);
    send_cigar();

    // Indel runs across clips and unknown codes, misplaced clips, zero lengths.
    add_element(OP_I, 1);
    add_element(OP_I, 1);
    add_element(OP_S, 0);
    add_element(OP_D, 2);
    add_element(OP_D, 3);
    add_element(OP_UNKNOWN_LO, 0);
    add_element(OP_I, 1);
    add_element(OP_H, 2);
    add_element(OP_UNKNOWN_HI, 6);
    add_element(OP_M, 0);
    send_cigar();
  endtask

  task automatic test_sum_saturation();
    repeat (18) add_element(OP_M, LEN_MAX);
    send_cigar();
    repeat (18) add_element(OP_I, LEN_MAX);
    repeat (18) add_element(OP_D, LEN_MAX);
    repeat (18) add_element(OP_P, LEN_MAX);
    add_element(OP_X, LEN_MAX);
    send_cigar();
  endtask

  task automatic test_random();
    int sent;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      queue_random_cigar();
      sent += cigar_ops.size();
      send_cigar();
    end
  endtask

  // An indel run long enough to drive the indel error count to its ceiling, then a
  // long stretch of misplaced clips and padding.
  task automatic test_count_saturation();
    repeat (INDEL_RUN) send_element(OP_I, 1, 1'b0);
    send_element(OP_M, 1, 1'b1);
    repeat (CLIP_TRIPLES) begin
      send_element(OP_H, 0, 1'b0);
      send_element(OP_S, 0, 1'b0);
      send_element(OP_P, 0, 1'b0);
    end
    send_element(OP_M, 1, 1'b1);
  endtask

  always @(posedge clk) begin : summary_monitor
    cigar_summary_t want;
    cigar_summary_t got;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.ref_length = res_ch.ref_length;
      got.padded_ref_length = res_ch.padded_ref_length;
      got.read_length = res_ch.read_length;
      got.left_clipped = res_ch.left_clipped;
      got.right_clipped = res_ch.right_clipped;
      got.zero_len_errors = res_ch.zero_len_errors;
      got.hard_clip_errors = res_ch.hard_clip_errors;
      got.soft_clip_errors = res_ch.soft_clip_errors;
      got.indel_repeat_errors = res_ch.indel_repeat_errors;
      got.pad_at_end_error = res_ch.pad_at_end_error;
      got.pad_place_errors = res_ch.pad_place_errors;
      got.no_real_op = res_ch.no_real_op;
      if (expected_summaries.size() == 0) begin
        report_mismatch("summary with no CIGAR pending", 0, got.ref_length);
      end else begin
        want = expected_summaries.pop_front();
        compare_field("ref_length", want.ref_length, got.ref_length);
        compare_field("padded_ref_length", want.padded_ref_length, got.padded_ref_length);
        compare_field("read_length", want.read_length, got.read_length);
        compare_field("left_clipped", want.left_clipped, got.left_clipped);
        compare_field("right_clipped", want.right_clipped, got.right_clipped);
        compare_field("zero_len_errors", want.zero_len_errors, got.zero_len_errors);
        compare_field("hard_clip_errors", want.hard_clip_errors, got.hard_clip_errors);
        compare_field("soft_clip_errors", want.soft_clip_errors, got.soft_clip_errors);
        compare_field("indel_repeat_errors", want.indel_repeat_errors,
                      got.indel_repeat_errors);
        compare_field("pad_at_end_error", want.pad_at_end_error, got.pad_at_end_error);
        compare_field("pad_place_errors", want.pad_place_errors, got.pad_place_errors);
        compare_field("no_real_op", want.no_real_op, got.no_real_op);
      end
    end

    // The result side stalls in random bursts while idle_on is set.
    if (ready_hold != 0) begin
      ready_hold = ready_hold - 1;
      res_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      ready_hold = $urandom_range(0, 15);
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: run exceeded %0d cycles", $realtime, CYCLE_LIMIT);
    $display("cigar_stream_checker test failed");
    $finish;
  end

  initial begin
    elem_ch.valid = 1'b0;
    elem_ch.element_op = OP_M;
    elem_ch.element_len = '0;
    elem_ch.is_last = 1'b0;
    res_ch.ready = 1'b0;
    clear_cigar_state();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_sum_saturation();
    test_random();
    // The final stretch runs with both sides always willing.
    idle_on = 1'b0;
    test_count_saturation();
    elem_ch.valid <= 1'b0;

    for (int k = 0; k < 2000 && expected_summaries.size() != 0; k++) @(posedge clk);
    if (expected_summaries.size() != 0) begin
      report_mismatch("summaries never delivered", expected_summaries.size(), 0);
    end
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("cigar_stream_checker test passed");
    end else begin
      $display("cigar_stream_checker test failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/csc_pkg.sv
rtl/csc_elem_if.sv
rtl/csc_res_if.sv
rtl/csc_front.sv
rtl/csc_queue.sv
rtl/csc_back.sv
rtl/cigar_stream_checker.sv
rtl/csc_checker.sv
tb/cigar_stream_checker_test.sv
